### src/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the block allocator modules.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define FBFA_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("fbfa: invariant violated");

// Checks that a condition implies a consequence at the same clock edge.
`define FBFA_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fbfa: implication violated");

// Checks that a condition implies a consequence at the next clock edge.
`define FBFA_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("fbfa: sequence violated");

`endif

### src/fbfa_pkg.sv
// ============================================================================
// Block allocator package
// Constants, codes, types and a helper function of the block allocator.
// ============================================================================
package fbfa_pkg;

    localparam int NUM_BLOCKS_DEF = 256;

    localparam int POOL_W = 21;
    localparam int BSZ_W  = 13;
    localparam int FUNC_W = 2;
    localparam int IDX_W  = 8;
    localparam int OFF_W  = 20;
    localparam int CNT_W  = 9;
    localparam int ACC_W  = 22;
    localparam int REG_W  = 1;

    localparam logic [BSZ_W-1:0] HDR_BYTES       = 13'd8;
    localparam logic [BSZ_W-1:0] MAX_BLOCK_BYTES = 13'd4096;

    localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd2;

    localparam logic [REG_W-1:0] REG_POOL_BYTES  = 1'b0;
    localparam logic [REG_W-1:0] REG_BLOCK_BYTES = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LINK,
        ST_ALLOC
    } state_t;

    typedef struct packed {
        logic load_round;
        logic check;
        logic link;
        logic alloc_rd;
        logic alloc_wb;
        logic free_op;
        logic reject;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic check_fail;
        logic link_last;
    } sts_t;

    function automatic logic [BSZ_W-1:0] round_block(input logic [BSZ_W-1:0] n);
        logic [BSZ_W-1:0] c;
        c = n;
        if (c == '0)
            c = BSZ_W'(1);
        if (c > MAX_BLOCK_BYTES)
            c = MAX_BLOCK_BYTES;
        c = c + BSZ_W'(7);
        return {c[BSZ_W-1:3], 3'b000};
    endfunction

endpackage

### src/fbfa_ram.sv
// ============================================================================
// Generic RAM
// Single write port, single read port, registered read data.
// ============================================================================
module fbfa_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/fbfa_ctrl.sv
// ============================================================================
// Block allocator controller
// Sequences init, allocate and free words and drives datapath commands.
// ============================================================================
`include "assert_macros.svh"

module fbfa_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [fbfa_pkg::FUNC_W-1:0]  func,
    input  fbfa_pkg::sts_t               sts,
    output logic                         busy,
    output fbfa_pkg::cmd_t               cmd
);

    fbfa_pkg::state_t state_reg;
    fbfa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fbfa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fbfa_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (func == fbfa_pkg::FUNC_INIT)
                        state_next = fbfa_pkg::ST_CHECK;
                    else if (func == fbfa_pkg::FUNC_ALLOC && !sts.empty)
                        state_next = fbfa_pkg::ST_ALLOC;
                end
            end
            fbfa_pkg::ST_CHECK:
            begin
                state_next = sts.check_fail ? fbfa_pkg::ST_IDLE : fbfa_pkg::ST_LINK;
            end
            fbfa_pkg::ST_LINK:
            begin
                if (sts.link_last)
                    state_next = fbfa_pkg::ST_IDLE;
            end
            fbfa_pkg::ST_ALLOC:
            begin
                state_next = fbfa_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = fbfa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            fbfa_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    unique case (func)
                        fbfa_pkg::FUNC_INIT:
                        begin
                            cmd.load_round = 1'b1;
                        end
                        fbfa_pkg::FUNC_ALLOC:
                        begin
                            cmd.alloc_rd = !sts.empty;
                            cmd.reject   = sts.empty;
                        end
                        fbfa_pkg::FUNC_FREE:
                        begin
                            cmd.free_op = 1'b1;
                        end
                        default:
                        begin
                            cmd.reject = 1'b1;
                        end
                    endcase
                end
            end
            fbfa_pkg::ST_CHECK:
            begin
                cmd.check = 1'b1;
            end
            fbfa_pkg::ST_LINK:
            begin
                cmd.link = 1'b1;
            end
            fbfa_pkg::ST_ALLOC:
            begin
                cmd.alloc_wb = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    `FBFA_ASSERT(a_cmd_onehot0, clk, rst_n, $onehot0(cmd))
    `FBFA_ASSERT_NEXT(a_alloc_one_cycle, clk, rst_n, state_reg == fbfa_pkg::ST_ALLOC, state_reg == fbfa_pkg::ST_IDLE)
    `FBFA_ASSERT_IMPL(a_busy_blocks_cmds, clk, rst_n, busy, !cmd.free_op && !cmd.reject && !cmd.alloc_rd)

endmodule

### src/fbfa_dp.sv
// ============================================================================
// Block allocator datapath
// Configuration, free list head, counters, link memory and result word.
// ============================================================================
`include "assert_macros.svh"

module fbfa_dp #(
    parameter int NUM_BLOCKS = fbfa_pkg::NUM_BLOCKS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [fbfa_pkg::REG_W-1:0]   wr_index,
    input  logic [fbfa_pkg::POOL_W-1:0]  wr_data,
    input  logic [fbfa_pkg::IDX_W-1:0]   block_index,
    input  fbfa_pkg::cmd_t               cmd,
    output fbfa_pkg::sts_t               sts,
    output logic                         done,
    output logic                         ok,
    output logic [fbfa_pkg::IDX_W-1:0]   alloc_index,
    output logic [fbfa_pkg::OFF_W-1:0]   alloc_offset,
    output logic [fbfa_pkg::CNT_W-1:0]   free_count
);

    localparam int LW = $clog2(NUM_BLOCKS + 1);
    localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CW = (LW > fbfa_pkg::IDX_W) ? LW : fbfa_pkg::IDX_W;
    localparam int PW = LW + fbfa_pkg::BSZ_W + 1;
    localparam logic [LW-1:0] END_LINK = LW'(NUM_BLOCKS);
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_BLOCKS - 1);

    logic [fbfa_pkg::POOL_W-1:0] pool_reg;
    logic [fbfa_pkg::BSZ_W-1:0]  bsz_reg;
    logic [fbfa_pkg::BSZ_W-1:0]  rounded_reg, rounded_next;
    logic [LW-1:0]               head_reg, head_next;
    logic [LW-1:0]               count_reg, count_next;
    logic [LW-1:0]               free_reg, free_next;
    logic [fbfa_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic [AW-1:0]               lidx_reg, lidx_next;
    logic                        done_reg, done_next;
    logic                        ok_reg, ok_next;
    logic [fbfa_pkg::IDX_W-1:0]  aidx_reg, aidx_next;
    logic [fbfa_pkg::OFF_W-1:0]  aoff_reg, aoff_next;
    logic [fbfa_pkg::CNT_W-1:0]  fcnt_reg, fcnt_next;

    logic [fbfa_pkg::ACC_W-1:0]  check_sum;
    logic [fbfa_pkg::ACC_W-1:0]  link_sum;
    logic [fbfa_pkg::ACC_W-1:0]  pool_ext;
    logic [LW-1:0]               lidx_plus;
    logic [LW-1:0]               link_val;
    logic [PW-1:0]               off_sum;
    logic                        free_valid;

    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [LW-1:0]               mem_wdata;
    logic [LW-1:0]               mem_rdata;

    fbfa_ram #(
        .WIDTH (LW),
        .DEPTH (NUM_BLOCKS)
    ) u_links (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (cmd.alloc_rd),
        .rd_addr (head_reg[AW-1:0]),
        .rd_data (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_reg <= '0;
            bsz_reg  <= fbfa_pkg::HDR_BYTES;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                fbfa_pkg::REG_POOL_BYTES:
                begin
                    pool_reg <= wr_data;
                end
                fbfa_pkg::REG_BLOCK_BYTES:
                begin
                    bsz_reg <= wr_data[fbfa_pkg::BSZ_W-1:0];
                end
                default:
                begin
                    pool_reg <= pool_reg;
                end
            endcase
        end
    end

    assign pool_ext   = fbfa_pkg::ACC_W'(pool_reg);
    assign check_sum  = fbfa_pkg::ACC_W'(fbfa_pkg::HDR_BYTES) + fbfa_pkg::ACC_W'(rounded_reg);
    assign link_sum   = acc_reg + fbfa_pkg::ACC_W'(rounded_reg);
    assign lidx_plus  = LW'(lidx_reg) + LW'(1);
    assign link_val   = sts.link_last ? END_LINK : lidx_plus;
    assign off_sum    = PW'(fbfa_pkg::HDR_BYTES) + PW'(head_reg) * PW'(rounded_reg);
    assign free_valid = CW'(block_index) < CW'(count_reg);

    assign sts.empty      = head_reg == END_LINK;
    assign sts.check_fail = check_sum > pool_ext;
    assign sts.link_last  = (link_sum > pool_ext) || (lidx_reg == LAST_IDX);

    always_comb
    begin
        rounded_next = rounded_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        free_next    = free_reg;
        acc_next     = acc_reg;
        lidx_next    = lidx_reg;
        done_next    = 1'b0;
        ok_next      = 1'b0;
        aidx_next    = '0;
        aoff_next    = '0;
        mem_we       = 1'b0;
        mem_waddr    = lidx_reg;
        mem_wdata    = link_val;

        if (cmd.load_round)
        begin
            rounded_next = fbfa_pkg::round_block(bsz_reg);
        end

        if (cmd.check)
        begin
            acc_next  = check_sum;
            lidx_next = '0;
            if (sts.check_fail)
            begin
                count_next = '0;
                free_next  = '0;
                head_next  = END_LINK;
                done_next  = 1'b1;
            end
        end

        if (cmd.link)
        begin
            mem_we    = 1'b1;
            acc_next  = link_sum;
            lidx_next = lidx_reg + AW'(1);
            if (sts.link_last)
            begin
                count_next = lidx_plus;
                free_next  = lidx_plus;
                head_next  = '0;
                done_next  = 1'b1;
                ok_next    = 1'b1;
            end
        end

        if (cmd.alloc_wb)
        begin
            head_next = mem_rdata;
            free_next = (free_reg != '0) ? free_reg - LW'(1) : free_reg;
            done_next = 1'b1;
            ok_next   = 1'b1;
            aidx_next = fbfa_pkg::IDX_W'(head_reg);
            aoff_next = fbfa_pkg::OFF_W'(off_sum);
        end

        if (cmd.free_op)
        begin
            done_next = 1'b1;
            if (free_valid)
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(block_index);
                mem_wdata = head_reg;
                head_next = LW'(block_index);
                free_next = (free_reg < count_reg) ? free_reg + LW'(1) : free_reg;
                ok_next   = 1'b1;
            end
        end

        if (cmd.reject)
        begin
            done_next = 1'b1;
        end

        fcnt_next = fbfa_pkg::CNT_W'(free_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rounded_reg <= fbfa_pkg::HDR_BYTES;
            head_reg    <= END_LINK;
            count_reg   <= '0;
            free_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            rounded_reg <= rounded_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            free_reg    <= free_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        lidx_reg <= lidx_next;
        ok_reg   <= ok_next;
        aidx_reg <= aidx_next;
        aoff_reg <= aoff_next;
        fcnt_reg <= fcnt_next;
    end

    assign done         = done_reg;
    assign ok           = ok_reg;
    assign alloc_index  = aidx_reg;
    assign alloc_offset = aoff_reg;
    assign free_count   = fcnt_reg;

    `FBFA_ASSERT(a_free_le_count, clk, rst_n, free_reg <= count_reg)
    `FBFA_ASSERT(a_head_in_range, clk, rst_n, (head_reg == END_LINK) || (head_reg < count_reg))

endmodule

### src/fixed_block_free_list_allocator_core.sv
// ============================================================================
// Fixed-size block allocator core
// Linked free list of equal blocks in a pool behind one 8-byte header word.
// ============================================================================
// A word is accepted at a rising edge with start high and busy low. Free, a
// rejected allocate and an unknown function answer on the next cycle; an
// allocate reads the link memory, whose read data is registered, and answers
// from the ALLOC state. Init keeps busy high through CHECK and then LINK,
// which writes one link entry per cycle through the memory's single write
// port; a pool too small for one block ends in CHECK. Each result sits on the
// output ports for exactly one cycle, marked by done, and cannot be held off,
// so it must be captured in that cycle. The user must write registers only
// while busy is low and no result is pending; the block does not enforce it.
module fixed_block_free_list_allocator_core #(
    parameter int NUM_BLOCKS = fbfa_pkg::NUM_BLOCKS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [fbfa_pkg::FUNC_W-1:0]  func,
    input  logic [fbfa_pkg::IDX_W-1:0]   block_index,
    input  logic                         wr_en,
    input  logic [fbfa_pkg::REG_W-1:0]   wr_index,
    input  logic [fbfa_pkg::POOL_W-1:0]  wr_data,
    output logic                         done,
    output logic                         ok,
    output logic [fbfa_pkg::IDX_W-1:0]   alloc_index,
    output logic [fbfa_pkg::OFF_W-1:0]   alloc_offset,
    output logic [fbfa_pkg::CNT_W-1:0]   free_count
);

    fbfa_pkg::cmd_t cmd;
    fbfa_pkg::sts_t sts;

    fbfa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .sts   (sts),
        .busy  (busy),
        .cmd   (cmd)
    );

    fbfa_dp #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .block_index  (block_index),
        .cmd          (cmd),
        .sts          (sts),
        .done         (done),
        .ok           (ok),
        .alloc_index  (alloc_index),
        .alloc_offset (alloc_offset),
        .free_count   (free_count)
    );

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// Block allocator core testbench
// Drives init, allocate, free and unknown function words into the core under
// several pool and block size settings. A shadow free list in the bench
// predicts every reply, and each done strobe is checked field by field.
// ============================================================================
module testbench;

    localparam logic [fbfa_pkg::FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;
    localparam int POOL_MAX = (1 << fbfa_pkg::POOL_W) - 1;
    localparam int QUIET_LIMIT = 3000;

    typedef struct packed {
        logic                       ok;
        logic [fbfa_pkg::IDX_W-1:0] index;
        logic [fbfa_pkg::OFF_W-1:0] offset;
        logic [fbfa_pkg::CNT_W-1:0] count;
    } alloc_reply_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic [fbfa_pkg::FUNC_W-1:0]   func = '0;
    logic [fbfa_pkg::IDX_W-1:0]    block_index = '0;
    logic                          wr_en = 1'b0;
    logic [fbfa_pkg::REG_W-1:0]    wr_index = '0;
    logic [fbfa_pkg::POOL_W-1:0]   wr_data = '0;
    logic                          busy;
    logic                          done;
    logic                          ok;
    logic [fbfa_pkg::IDX_W-1:0]    alloc_index;
    logic [fbfa_pkg::OFF_W-1:0]    alloc_offset;
    logic [fbfa_pkg::CNT_W-1:0]    free_count;

    logic [fbfa_pkg::POOL_W-1:0]   cfg_pool = '0;
    logic [fbfa_pkg::BSZ_W-1:0]    cfg_block = fbfa_pkg::BSZ_W'(8);
    logic [fbfa_pkg::CNT_W-1:0]    sh_head = fbfa_pkg::CNT_W'(fbfa_pkg::NUM_BLOCKS_DEF);
    logic [fbfa_pkg::CNT_W-1:0]    sh_link [fbfa_pkg::NUM_BLOCKS_DEF];
    logic [fbfa_pkg::CNT_W-1:0]    sh_blocks = '0;
    logic [fbfa_pkg::CNT_W-1:0]    sh_free = '0;
    logic [fbfa_pkg::BSZ_W-1:0]    sh_rounded = fbfa_pkg::BSZ_W'(8);

    alloc_reply_t        owed_replies [$];
    int                  mismatches = 0;
    int                  gap_pct = 0;
    int                  quiet_cycles = 0;

    fixed_block_free_list_allocator_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .block_index  (block_index),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .done         (done),
        .ok           (ok),
        .alloc_index  (alloc_index),
        .alloc_offset (alloc_offset),
        .free_count   (free_count)
    );

    always #10 clk = ~clk;

    function automatic logic [fbfa_pkg::BSZ_W-1:0] rounded_size(
        input logic [fbfa_pkg::BSZ_W-1:0] req);
        int b;
        b = (req == '0) ? 1 : int'(req);
        if (b > int'(fbfa_pkg::MAX_BLOCK_BYTES))
            b = int'(fbfa_pkg::MAX_BLOCK_BYTES);
        return fbfa_pkg::BSZ_W'((b + 7) / 8 * 8);
    endfunction

    function automatic alloc_reply_t apply_word(input logic [fbfa_pkg::FUNC_W-1:0] f,
                                                input logic [fbfa_pkg::IDX_W-1:0] idx);
        alloc_reply_t r;
        logic [fbfa_pkg::ACC_W-1:0] n;
        r = '0;
        case (f)
            fbfa_pkg::FUNC_INIT:
            begin
                sh_rounded = rounded_size(cfg_block);
                if (fbfa_pkg::ACC_W'(cfg_pool) < fbfa_pkg::ACC_W'(sh_rounded)
                                                 + fbfa_pkg::ACC_W'(fbfa_pkg::HDR_BYTES))
                begin
                    sh_blocks = '0;
                    sh_free = '0;
                    sh_head = fbfa_pkg::CNT_W'(fbfa_pkg::NUM_BLOCKS_DEF);
                end
                else
                begin
                    n = (fbfa_pkg::ACC_W'(cfg_pool) - fbfa_pkg::ACC_W'(fbfa_pkg::HDR_BYTES))
                        / fbfa_pkg::ACC_W'(sh_rounded);
                    if (n > fbfa_pkg::ACC_W'(fbfa_pkg::NUM_BLOCKS_DEF))
                        n = fbfa_pkg::ACC_W'(fbfa_pkg::NUM_BLOCKS_DEF);
                    for (int i = 0; i < int'(n); i++)
                        sh_link[i] = (i + 1 < int'(n)) ? fbfa_pkg::CNT_W'(i + 1)
                                                       : fbfa_pkg::CNT_W'(fbfa_pkg::NUM_BLOCKS_DEF);
                    sh_blocks = fbfa_pkg::CNT_W'(n);
                    sh_free = fbfa_pkg::CNT_W'(n);
                    sh_head = '0;
                    r.ok = 1'b1;
                end
            end
            fbfa_pkg::FUNC_ALLOC:
            begin
                if (sh_head < fbfa_pkg::CNT_W'(fbfa_pkg::NUM_BLOCKS_DEF))
                begin
                    r.index = sh_head[fbfa_pkg::IDX_W-1:0];
                    r.offset = fbfa_pkg::OFF_W'(fbfa_pkg::ACC_W'(fbfa_pkg::HDR_BYTES)
                               + fbfa_pkg::ACC_W'(sh_head[fbfa_pkg::IDX_W-1:0])
                                 * fbfa_pkg::ACC_W'(sh_rounded));
                    sh_head = sh_link[sh_head[fbfa_pkg::IDX_W-1:0]];
                    if (sh_free != '0)
                        sh_free = sh_free - fbfa_pkg::CNT_W'(1);
                    r.ok = 1'b1;
                end
            end
            fbfa_pkg::FUNC_FREE:
            begin
                if (fbfa_pkg::CNT_W'(idx) < sh_blocks)
                begin
                    sh_link[idx] = sh_head;
                    sh_head = fbfa_pkg::CNT_W'(idx);
                    if (sh_free < sh_blocks)
                        sh_free = sh_free + fbfa_pkg::CNT_W'(1);
                    r.ok = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.count = sh_free;
        return r;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        alloc_reply_t want;
        if (rst_n && done)
        begin
            if (owed_replies.size() == 0)
            begin
                $display("%0t: reply with none expected, expected none actual ok=%0d cnt=%0d",
                         $time, ok, free_count);
                mismatches++;
            end
            else
            begin
                want = owed_replies.pop_front();
                compare_field("ok", int'(want.ok), int'(ok));
                compare_field("alloc_index", int'(want.index), int'(alloc_index));
                compare_field("alloc_offset", int'(want.offset), int'(alloc_offset));
                compare_field("free_count", int'(want.count), int'(free_count));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || wr_en)
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: timeout with %0d replies outstanding", $time,
                         owed_replies.size());
                $display("*** FAILED ***");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input logic [fbfa_pkg::FUNC_W-1:0] f,
                             input logic [fbfa_pkg::IDX_W-1:0] idx,
                             output alloc_reply_t reply);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        func        <= f;
        block_index <= idx;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        reply = apply_word(f, idx);
        owed_replies.push_back(reply);
    endtask

    task automatic settle_block();
        start <= 1'b0;
        while (owed_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input int pool, input int bsz);
        settle_block();
        wr_en    <= 1'b1;
        wr_index <= fbfa_pkg::REG_POOL_BYTES;
        wr_data  <= fbfa_pkg::POOL_W'(pool);
        @(posedge clk);
        cfg_pool = fbfa_pkg::POOL_W'(pool);
        wr_index <= fbfa_pkg::REG_BLOCK_BYTES;
        wr_data  <= fbfa_pkg::POOL_W'(fbfa_pkg::BSZ_W'(bsz));
        @(posedge clk);
        cfg_block = fbfa_pkg::BSZ_W'(bsz);
        wr_en <= 1'b0;
    endtask

    task automatic test_before_init();
        alloc_reply_t r;
        send_word(fbfa_pkg::FUNC_FREE, 8'd0, r);
        send_word(fbfa_pkg::FUNC_ALLOC, 8'd0, r);
        send_word(FUNC_UNKNOWN, 8'hFF, r);
        send_word(fbfa_pkg::FUNC_INIT, 8'd0, r);
    endtask

    task automatic test_block_rounding();
        alloc_reply_t r;
        set_config(16, 0);
        send_word(fbfa_pkg::FUNC_INIT, 8'd0, r);
        send_word(fbfa_pkg::FUNC_ALLOC, 8'd0, r);
        send_word(fbfa_pkg::FUNC_ALLOC, 8'd0, r);
        send_word(fbfa_pkg::FUNC_FREE, 8'd0, r);
        send_word(fbfa_pkg::FUNC_FREE, 8'd0, r);
        send_word(fbfa_pkg::FUNC_ALLOC, 8'd0, r);
        send_word(fbfa_pkg::FUNC_ALLOC, 8'd0, r);
        send_word(fbfa_pkg::FUNC_FREE, 8'd1, r);
    endtask

    task automatic test_pool_limits();
        alloc_reply_t r;
        set_config(4103, 8191);
        send_word(fbfa_pkg::FUNC_INIT, 8'd0, r);
        set_config(4104, 4096);
        send_word(fbfa_pkg::FUNC_INIT, 8'd0, r);
        send_word(fbfa_pkg::FUNC_ALLOC, 8'd0, r);
        set_config(POOL_MAX, 4096);
        send_word(fbfa_pkg::FUNC_INIT, 8'd0, r);
        send_word(fbfa_pkg::FUNC_FREE, 8'hFF, r);
        send_word(fbfa_pkg::FUNC_ALLOC, 8'd0, r);
        set_config(POOL_MAX, 1);
        send_word(fbfa_pkg::FUNC_INIT, 8'd0, r);
        send_word(fbfa_pkg::FUNC_ALLOC, 8'd0, r);
    endtask

    task automatic test_random_traffic(input int n_words, input int idle_pct);
        alloc_reply_t r;
        logic [fbfa_pkg::IDX_W-1:0] held [$];
        int sent;
        int pick;
        int bsz;
        int pool;
        int blocks;
        int rsz;
        int k;
        int burst;
        gap_pct = idle_pct;
        sent = 0;
        while (sent < n_words)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                bsz = $urandom_range((1 << fbfa_pkg::BSZ_W) - 1);
                pool = $urandom_range(POOL_MAX);
            end
            else
            begin
                if (pick < 70)
                    bsz = $urandom_range(64, 1);
                else if (pick < 78)
                    bsz = 0;
                else
                    bsz = $urandom_range((1 << fbfa_pkg::BSZ_W) - 1, 65);
                rsz = int'(rounded_size(fbfa_pkg::BSZ_W'(bsz)));
                pick = $urandom_range(99);
                if (pick < 75)
                    blocks = $urandom_range(12, 1);
                else if (pick < 95)
                    blocks = $urandom_range(255, 13);
                else
                    blocks = $urandom_range(300, 256);
                pool = 8 + blocks * rsz + $urandom_range(rsz - 1);
                if (pool > POOL_MAX)
                    pool = POOL_MAX;
            end
            set_config(pool, bsz);
            held.delete();
            send_word(fbfa_pkg::FUNC_INIT, fbfa_pkg::IDX_W'($urandom), r);
            sent++;
            burst = $urandom_range(80, 20);
            while (burst > 0 && sent < n_words)
            begin
                pick = $urandom_range(99);
                if (pick < 45)
                begin
                    send_word(fbfa_pkg::FUNC_ALLOC, fbfa_pkg::IDX_W'($urandom), r);
                    if (r.ok)
                        held.push_back(r.index);
                end
                else if (pick < 85 && held.size() != 0)
                begin
                    k = $urandom_range(held.size() - 1);
                    send_word(fbfa_pkg::FUNC_FREE, held[k], r);
                    held.delete(k);
                end
                else if (pick < 93)
                    send_word(fbfa_pkg::FUNC_FREE, fbfa_pkg::IDX_W'($urandom), r);
                else if (pick < 97)
                    send_word(FUNC_UNKNOWN, fbfa_pkg::IDX_W'($urandom), r);
                else
                begin
                    send_word(fbfa_pkg::FUNC_INIT, fbfa_pkg::IDX_W'($urandom), r);
                    held.delete();
                end
                sent++;
                burst--;
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_before_init();
        test_block_rounding();
        test_pool_limits();
        test_random_traffic(480, 7);
        test_random_traffic(480, 55);
        test_random_traffic(480, 0);
        settle_block();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/fbfa_pkg.sv
src/fbfa_ram.sv
src/fbfa_ctrl.sv
src/fbfa_dp.sv
src/fixed_block_free_list_allocator_core.sv
tb/sv/testbench.sv
